[sv/fpdf_pkg.sv]
// ----------------------------------------------------------------------------
// fpdf_pkg: shared types and constants of the decimal formatter
// Job record passed from the digit extractor to the character sequencer,
// ASCII codes, register indexes and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdf_pkg;

  // Field widths
  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 7;
  localparam int DP_W     = 4;
  localparam int BLEN_W   = 6;
  localparam int DIGIT_W  = 4;
  localparam int NDIGITS  = 10;   // decimal digits of a 32-bit magnitude
  localparam int SIG_W    = 4;
  localparam int LEN_W    = 5;    // up to 16 digits with padding
  localparam int POS_W    = 4;

  // Configuration register indexes
  localparam logic CFG_DECIMAL_PLACES = 1'b0;
  localparam logic CFG_BUFFER_LENGTH  = 1'b1;

  // Reset values of the registers
  localparam logic [DP_W-1:0]   DP_RESET   = 4'd0;
  localparam logic [BLEN_W-1:0] BLEN_RESET = 6'd12;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;

  // Reciprocal of ten for the digit extractor: q = (m * RECIP10) >> RECIP_SH
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;

  // Job queue sizing
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One formatted value, ready for the sequencer
  typedef struct packed {
    logic [NDIGITS-1:0][DIGIT_W-1:0] digits;  // least significant first
    logic [SIG_W-1:0]                sig;     // significant digit count
    logic [LEN_W-1:0]                len;     // digit count with padding
    logic [DP_W-1:0]                 dp;      // clamped decimal places
    logic                            neg;
    logic                            err;     // text does not fit
  } fpdf_job_t;

  // Digit at a position; positions beyond the significant ones are padding
  function automatic logic [DIGIT_W-1:0] digit_at(
    input logic [NDIGITS-1:0][DIGIT_W-1:0] digits,
    input logic [POS_W-1:0]                pos,
    input logic [SIG_W-1:0]                sig
  );
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int i = 0; i < NDIGITS; i++) begin
      if (pos == POS_W'(i) && pos < sig) begin
        d = digits[i];
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[sv/fpdf_if.sv]
// ----------------------------------------------------------------------------
// fpdf_if: item channels of the decimal formatter
// Input channel carries one signed value; output channel one character.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpdf_num_if;
  import fpdf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fpdf_text_if;
  import fpdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              error;

  modport source (output valid, output character, output last, output error, input ready);
  modport sink   (input valid, input character, input last, input error, output ready);
endinterface

`default_nettype wire

[sv/fixed_point_decimal_formatter_unit.sv]
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_unit: signed integer to decimal text
// Formats one value into ASCII characters with optional fixed decimal point.
// ----------------------------------------------------------------------------
// Usage:
//   num  : one signed 32-bit value per item (valid/ready).
//   text : one ASCII character per item, most significant first; last marks
//          the final character of a value. A text that does not fit
//          buffer_length comes out as one item with error set, character 0.
//   cfg  : cfg_we/cfg_index/cfg_data write decimal_places (index 0) and
//          buffer_length (index 1); write only while the block is idle.
// Operation:
//   The extractor needs one reciprocal multiply per digit (D = significant
//   digits, 0..10). The sequencer loads a job and then emits its characters
//   (up to 18). A two-entry job queue lets both run at once.
// Reset clears all control state and sets decimal_places to 0 and
// buffer_length to 12. A stalled receiver holds the output register; the
// queue then fills and num.ready stays low once the extractor holds a job too.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_decimal_formatter_unit
  import fpdf_pkg::*;
#(
  parameter int MAX_DECIMAL_PLACES = 15
) (
  input  wire logic              clk,
  input  wire logic              rst,
  fpdf_num_if.sink               num,
  fpdf_text_if.source            text,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [BLEN_W-1:0] cfg_data
);

  logic [DP_W-1:0]   decimal_places;
  logic [BLEN_W-1:0] buffer_length;

  logic              fq_valid;
  logic              fq_ready;
  fpdf_job_t         fq_job;
  logic              qb_valid;
  logic              qb_ready;
  fpdf_job_t         qb_job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_places <= DP_RESET;
      buffer_length  <= BLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECIMAL_PLACES: decimal_places <= cfg_data[DP_W-1:0];
        CFG_BUFFER_LENGTH:  buffer_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Digit extraction
  fpdf_front #(
    .MAX_DECIMAL_PLACES(MAX_DECIMAL_PLACES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .num            (num),
    .decimal_places (decimal_places),
    .buffer_length  (buffer_length),
    .job_valid      (fq_valid),
    .job_ready      (fq_ready),
    .job            (fq_job)
  );

  // Job queue
  fpdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  // Character sequencing
  fpdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .text      (text)
  );

endmodule

`default_nettype wire

[sv/fpdf_front.sv]
// ----------------------------------------------------------------------------
// fpdf_front: value intake and digit extraction
// Takes a value, peels off one decimal digit per cycle with a reciprocal
// multiply, sizes the text and checks it against the buffer length.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdf_front
  import fpdf_pkg::*;
#(
  parameter int MAX_DECIMAL_PLACES = 15
) (
  input  wire logic              clk,
  input  wire logic              rst,
  fpdf_num_if.sink               num,
  input  wire logic [DP_W-1:0]   decimal_places,
  input  wire logic [BLEN_W-1:0] buffer_length,
  output      logic              job_valid,
  input  wire logic              job_ready,
  output      fpdf_job_t         job
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]                       state;
  logic [VALUE_W-1:0]               mag;
  logic [SIG_W-1:0]                 cnt;
  logic [NDIGITS-1:0][DIGIT_W-1:0]  digits;
  logic                             neg;
  logic [DP_W-1:0]                  dp;

  logic [DP_W-1:0]                  dp_clamped;
  logic [63:0]                      prod;
  logic [VALUE_W-1:0]               quot;
  logic [VALUE_W-1:0]               rem;
  logic [LEN_W-1:0]                 dp_plus1;
  logic [LEN_W-1:0]                 len;
  logic [BLEN_W-1:0]                total;

  assign num.ready = (state == F_IDLE);

  // Decimal places above the supported maximum are clamped
  always_comb begin
    dp_clamped = decimal_places;
    if (int'(decimal_places) > MAX_DECIMAL_PLACES) begin
      dp_clamped = DP_W'(MAX_DECIMAL_PLACES);
    end
  end

  // One digit: quotient by reciprocal, remainder by shift-and-subtract
  assign prod = 64'(mag) * 64'(RECIP10);
  assign quot = VALUE_W'(prod[63:RECIP_SH]);
  assign rem  = mag - {quot[VALUE_W-4:0], 3'b000} - {quot[VALUE_W-2:0], 1'b0};

  // Text size: padded digits, sign, point and terminator
  assign dp_plus1 = LEN_W'(dp) + LEN_W'(1);
  assign len      = (LEN_W'(cnt) > dp_plus1) ? LEN_W'(cnt) : dp_plus1;
  assign total    = BLEN_W'(len) + BLEN_W'(neg) + BLEN_W'(dp != '0) + BLEN_W'(1);

  // Job record
  assign job_valid  = (state == F_PUSH);
  assign job.digits = digits;
  assign job.sig    = cnt;
  assign job.len    = len;
  assign job.dp     = dp;
  assign job.neg    = neg;
  assign job.err    = (total > buffer_length);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (num.valid) state <= F_CONV;
        F_CONV: if (mag == '0) state <= F_PUSH;
        F_PUSH: if (job_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE && num.valid) begin
      neg <= num.value[VALUE_W-1];
      mag <= num.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(num.value))
                                  : VALUE_W'(num.value);
      cnt <= '0;
      dp  <= dp_clamped;
    end else if (state == F_CONV && mag != '0) begin
      digits[cnt] <= rem[DIGIT_W-1:0];
      mag         <= quot;
      cnt         <= cnt + SIG_W'(1);
    end
  end

endmodule

`default_nettype wire

[sv/fpdf_queue.sv]
// ----------------------------------------------------------------------------
// fpdf_queue: job queue between extractor and sequencer
// Small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdf_queue
  import fpdf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output      logic      push_ready,
  input  wire fpdf_job_t push_job,
  output      logic      pop_valid,
  input  wire logic      pop_ready,
  output      fpdf_job_t pop_job
);

  fpdf_job_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

[sv/fpdf_back.sv]
// ----------------------------------------------------------------------------
// fpdf_back: character sequencer
// Walks one job: sign, digits most significant first with the point in
// place, or a single error item. One character per cycle into an output
// register while the receiver does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdf_back
  import fpdf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      job_valid,
  output      logic      job_ready,
  input  wire fpdf_job_t job,
  fpdf_text_if.source    text
);

  logic                  busy;
  logic                  sign_pending;
  logic                  point_pending;
  logic [POS_W-1:0]      pos;
  fpdf_job_t             cur;

  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_last;
  logic                  out_error;

  logic                  step;
  logic [DIGIT_W-1:0]    digit;

  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;
  assign text.error     = out_error;

  assign job_ready = !busy;
  assign step      = busy && (!out_valid || text.ready);
  assign digit     = digit_at(cur.digits, pos, cur.sig);

  // Control: job load, walk, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      sign_pending  <= 1'b0;
      point_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end

      if (!busy) begin
        if (job_valid) begin
          busy          <= 1'b1;
          sign_pending  <= job.neg;
          point_pending <= 1'b0;
        end
      end else if (step) begin
        priority if (cur.err) begin
          busy <= 1'b0;
        end else if (sign_pending) begin
          sign_pending <= 1'b0;
        end else if (point_pending) begin
          point_pending <= 1'b0;
        end else begin
          if (pos == '0) begin
            busy <= 1'b0;
          end else if (cur.dp != '0 && pos == cur.dp) begin
            point_pending <= 1'b1;
          end
        end
      end
    end
  end

  // Datapath: job copy, position, output payload
  always_ff @(posedge clk) begin
    if (!busy && job_valid) begin
      cur <= job;
      pos <= POS_W'(job.len - LEN_W'(1));
    end else if (step) begin
      priority if (cur.err) begin
        out_char  <= CH_NUL;
        out_last  <= 1'b1;
        out_error <= 1'b1;
      end else if (sign_pending) begin
        out_char  <= CH_MINUS;
        out_last  <= 1'b0;
        out_error <= 1'b0;
      end else if (point_pending) begin
        out_char  <= CH_POINT;
        out_last  <= 1'b0;
        out_error <= 1'b0;
      end else begin
        out_char  <= CH_ZERO + CHAR_W'(digit);
        out_last  <= (pos == '0);
        out_error <= 1'b0;
        pos       <= pos - POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
